// ===== hdl/ffca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and constants for the first-fit cell allocator
// Field widths, status codes and word types used by the cell ring and the top.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int CELLS     = 1024;
    localparam int ID_BITS   = 10;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int CNT_BITS  = ADDR_BITS + 1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [10:0] alloc_size;
        logic [9:0]  owner_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  start_address;
        logic [10:0] freed_count;
    } rsp_t;

    // Command that the sequencer broadcasts to the ring on a shift cycle.
    typedef struct packed {
        logic               shift;   // rotate the ring by one cell
        logic               clear;   // clear the head tag, which matches the free id
        logic               write;   // tag the head cell with the owner id
        logic [ID_BITS-1:0] id;
    } ring_cmd_t;

endpackage : ffca_pkg
`default_nettype wire

// ===== hdl/ffca_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_cell: one owner tag of the rotating cell ring
// Holds one tag and takes its neighbor's tag on every shift cycle.
// ----------------------------------------------------------------------------
module ffca_cell
    import ffca_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift,
    input  wire logic [ID_BITS-1:0] tag_in,
    output      logic [ID_BITS-1:0] tag_out
);

    logic [ID_BITS-1:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (shift)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;

endmodule : ffca_cell
`default_nettype wire

// ===== hdl/ffca_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_ring: ring of owner tag cells
// Cell 0 is the head. On a shift the head tag, modified by the command, goes
// to the last cell and every other cell takes its upper neighbor's tag.
// ----------------------------------------------------------------------------
module ffca_ring
    import ffca_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ring_cmd_t          cmd,
    output      logic [ID_BITS-1:0] head
);

    logic [ID_BITS-1:0] tags [CELLS];
    logic [ID_BITS-1:0] wrap;

    always_comb
    begin
        wrap = tags[0];
        if (cmd.write)
        begin
            wrap = cmd.id;
        end
        else if (cmd.clear)
        begin
            wrap = '0;
        end
    end

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        ffca_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (cmd.shift),
            .tag_in  ((g == CELLS - 1) ? wrap : tags[(g + 1) % CELLS]),
            .tag_out (tags[g])
        );
    end

    assign head = tags[0];

endmodule : ffca_ring
`default_nettype wire

// ===== hdl/first_fit_cell_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_cell_allocator: first-fit contiguous cell allocator
// Owner tags live in a rotating ring of cells scanned one cell per cycle.
// ----------------------------------------------------------------------------
// Every request rotates the 1024-cell tag ring once to scan it, and the result
// then waits in the done state until the output is not stalled. An allocate
// makes one pass that finds the run and, when it succeeds, a second pass that
// writes the owner tag. The single head cell of the ring is the only place tags
// are read or written. The table is clear right after reset.
// ----------------------------------------------------------------------------
module first_fit_cell_allocator
    import ffca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire req_t        in_data,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      rsp_t        out_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

    state_t             state_reg;
    logic [10:0]        msize_reg;
    req_t               req_reg;
    logic [ADDR_BITS-1:0] pos_reg;  // cell address at the head
    logic [CNT_BITS-1:0] run_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic               found_reg;
    logic [ADDR_BITS-1:0] start_reg;
    rsp_t               rsp_reg;
    logic [ID_BITS-1:0] head;
    ring_cmd_t          cmd;

    logic [CNT_BITS-1:0] limit;
    logic               head_free;
    logic               in_range;
    logic [CNT_BITS-1:0] run_next;
    logic               hit;
    logic               in_run;
    logic               last;

    assign limit     = (msize_reg > CNT_BITS'(CELLS)) ? CNT_BITS'(CELLS) : msize_reg;
    assign head_free = (head == '0);
    assign in_range  = ({1'b0, pos_reg[ADDR_BITS-1:0]} < limit);
    assign run_next  = run_reg + 1'b1;
    assign hit       = head_free && in_range && !found_reg
                       && (run_next == req_reg.alloc_size);
    assign in_run    = (pos_reg[ADDR_BITS-1:0] >= start_reg)
                       && ({1'b0, pos_reg[ADDR_BITS-1:0]}
                           < {1'b0, start_reg} + req_reg.alloc_size);
    assign last      = (pos_reg[ADDR_BITS-1:0] == ADDR_BITS'(CELLS - 1));

    always_comb
    begin
        cmd       = '0;
        cmd.id    = req_reg.owner_id;
        cmd.shift = (state_reg == S_SCAN) || (state_reg == S_WRITE);
        cmd.clear = (state_reg == S_SCAN) && (req_reg.kind == KIND_FREE)
                    && (req_reg.owner_id != '0) && (head == req_reg.owner_id);
        cmd.write = (state_reg == S_WRITE) && in_run;
    end

    ffca_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg <= 11'(CELLS);
        end
        else if (cfg_we)
        begin
            msize_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            run_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
            req_reg   <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        pos_reg   <= '0;
                        run_reg   <= '0;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        start_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (cmd.clear)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (head_free && in_range)
                    begin
                        run_reg <= run_next;
                    end
                    else
                    begin
                        run_reg <= '0;
                    end
                    if (hit && (req_reg.kind == KIND_ALLOC) && (req_reg.owner_id != '0))
                    begin
                        found_reg <= 1'b1;
                        start_reg <= ADDR_BITS'({1'b0, pos_reg[ADDR_BITS-1:0]}
                                     + 1'b1 - req_reg.alloc_size);
                    end
                    if (last)
                    begin
                        pos_reg <= '0;
                        if (req_reg.kind == KIND_FREE)
                        begin
                            rsp_reg.status        <= ST_FREED;
                            rsp_reg.start_address <= '0;
                            rsp_reg.freed_count   <= cnt_reg + CNT_BITS'(cmd.clear);
                            state_reg             <= S_DONE;
                        end
                        else if (found_reg || (hit && (req_reg.owner_id != '0)))
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            rsp_reg   <= '{ST_NO_ROOM, 10'd0, 11'd0};
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WRITE:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (last)
                    begin
                        rsp_reg.status        <= ST_ALLOCATED;
                        rsp_reg.start_address <= start_reg;
                        rsp_reg.freed_count   <= '0;
                        state_reg             <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = rsp_reg;

    a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (req_reg.kind == KIND_ALLOC && found_reg))
        else $error("ring write outside a found allocation");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write && cmd.clear))
        else $error("write and clear at once");
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SCAN && pos_reg == '0))
        else $error("accepted word did not start a scan");
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && $past(cmd.write)) |-> (head == '0))
        else $error("allocation overwrote a used cell");

endmodule : first_fit_cell_allocator
`default_nettype wire
